[hw/rtl/set_assoc_lru_cache_model_top_assert.svh]
// ----------------------------------------------------------------------------
// set-associative lru cache model: assertion macros
// shared property forms, clocked on clk_i and held off while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_LRU_CACHE_MODEL_TOP_ASSERT_SVH
`define SET_ASSOC_LRU_CACHE_MODEL_TOP_ASSERT_SVH

// property that holds in the same cycle
`define SALC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// property whose consequent holds in the cycle after its antecedent
`define SALC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/salc_pkg.sv]
// ----------------------------------------------------------------------------
// salc_pkg
// types and constants shared by the set-associative lru cache model
// ----------------------------------------------------------------------------
package salc_pkg;

  // fixed field widths
  localparam int CMD_W        = 2;
  localparam int ADDR_W       = 64;
  localparam int CNT_W        = 32;
  localparam int AGE_W        = 3;
  localparam int SET_BITS_W   = 4;
  localparam int BLOCK_BITS_W = 6;
  localparam int WAYS_W       = 4;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 6;

  // oldest age a line can reach
  localparam logic [AGE_W-1:0] AGE_MAX = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD   = 2'd0,
    CMD_STORE  = 2'd1,
    CMD_MODIFY = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    OUT_HIT   = 2'd0,
    OUT_MISS  = 2'd1,
    OUT_EVICT = 2'd2
  } outcome_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SET_BITS   = 2'd0,
    CFG_BLOCK_BITS = 2'd1,
    CFG_WAYS       = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INDEX,
    ST_SCAN,
    ST_UPDATE
  } state_e;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [ADDR_W-1:0] address;
  } req_t;

  typedef struct packed {
    outcome_e         outcome;
    logic             last;
    logic [CNT_W-1:0] hit_count;
    logic [CNT_W-1:0] miss_count;
    logic [CNT_W-1:0] eviction_count;
  } rsp_t;

endpackage

[hw/rtl/set_assoc_lru_cache_model_top.sv]
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_model_top
// tag-only set-associative cache with lru replacement and running counts
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. One access has an
// index step that splits the address and reads the set's status row, a scan
// streaming the tags of ways 0..k-1 through the single tag ram port and its
// one comparator (k stops at the hitting way, else equals the ways in use),
// and an update that writes back the status row, and the tag on a miss. A
// modify runs two accesses. Each result is shown for exactly one cycle on
// rsp_valid_o and rsp_o, the cycle after its update, and cannot be held off;
// busy falls as a request's last result shows, so the next request may enter
// then. After reset a clearing pass wipes the status ram, with busy high;
// configuration writes are taken throughout and must only be made while busy is low.
`include "set_assoc_lru_cache_model_top_assert.svh"

module set_assoc_lru_cache_model_top import salc_pkg::*; #(
  parameter int MAX_SET_BITS  = 8,
  parameter int MAX_WAYS      = 8,
  parameter int ADDRESS_WIDTH = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  req_t                  req_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output logic                  rsp_valid_o,
  output rsp_t                  rsp_o
);

  localparam int SET_W  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int N_W    = $clog2(MAX_WAYS + 1);
  localparam int ROW_W  = MAX_WAYS * (AGE_W + 1);
  localparam int TAG_AW = SET_W + WAY_W;

  // configuration
  logic [SET_BITS_W-1:0]   set_bits_q;
  logic [BLOCK_BITS_W-1:0] block_bits_q;
  logic [WAYS_W-1:0]       ways_q;

  // control
  state_e state_q, state_d;
  logic   pass_q, pass_d;
  logic   [SET_W-1:0] clr_q, clr_d;

  // request and access registers
  logic [CMD_W-1:0]         cmd_q, cmd_d;
  logic [ADDR_W-1:0]        addr_q, addr_d;
  logic [SET_W-1:0]         set_q, set_d;
  logic [ADDRESS_WIDTH-1:0] tag_q, tag_d;
  logic [N_W-1:0]           n_q, n_d;

  // scan results
  logic [WAY_W-1:0] cur_q, cur_d;
  logic             found_q, found_d;
  logic [WAY_W-1:0] hit_way_q, hit_way_d;
  logic             vac_q, vac_d;
  logic [WAY_W-1:0] vac_way_q, vac_way_d;
  logic [WAY_W-1:0] vic_way_q, vic_way_d;
  logic [AGE_W-1:0] vic_age_q, vic_age_d;

  // running counts and result
  logic [CNT_W-1:0] hits_q, hits_d;
  logic [CNT_W-1:0] misses_q, misses_d;
  logic [CNT_W-1:0] evicts_q, evicts_d;
  rsp_t             rsp_q, rsp_d;
  logic             rsp_valid_q, rsp_valid_d;

  // address split
  logic [SET_W-1:0]         set_c;
  logic [ADDRESS_WIDTH-1:0] tag_c;
  logic [N_W-1:0]           n_c;

  // ram ports
  logic                     stat_we, stat_re;
  logic [SET_W-1:0]         stat_waddr;
  logic [ROW_W-1:0]         stat_wdata, stat_rdata;
  logic                     tag_we, tag_re;
  logic [TAG_AW-1:0]        tag_waddr, tag_raddr;
  logic [ADDRESS_WIDTH-1:0] tag_rdata;

  // status row fields
  logic [MAX_WAYS-1:0]            rd_valid, new_valid;
  logic [MAX_WAYS-1:0][AGE_W-1:0] rd_age, new_age;

  // scan compare and update selection
  logic             cur_valid;
  logic [AGE_W-1:0] cur_age;
  logic             tag_hit;
  logic             last_way;
  logic [WAY_W-1:0] upd_way;
  outcome_e         upd_outcome;
  logic             first_of_two;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q   <= '0;
      block_bits_q <= BLOCK_BITS_W'(1);
      ways_q       <= WAYS_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SET_BITS:   set_bits_q   <= cfg_wdata_i[SET_BITS_W-1:0];
        CFG_BLOCK_BITS: block_bits_q <= cfg_wdata_i[BLOCK_BITS_W-1:0];
        CFG_WAYS:       ways_q       <= cfg_wdata_i[WAYS_W-1:0];
        default: ;
      endcase
    end
  end

  salc_addr_split #(
    .MAX_SET_BITS  (MAX_SET_BITS),
    .MAX_WAYS      (MAX_WAYS),
    .ADDRESS_WIDTH (ADDRESS_WIDTH)
  ) u_split (
    .address_i    (addr_q),
    .set_bits_i   (set_bits_q),
    .block_bits_i (block_bits_q),
    .ways_i       (ways_q),
    .set_o        (set_c),
    .tag_o        (tag_c),
    .n_ways_o     (n_c)
  );

  // valid bits and ages, one row per set
  salc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (2 ** SET_W)
  ) u_stat_ram (
    .clk_i   (clk_i),
    .we_i    (stat_we),
    .waddr_i (stat_waddr),
    .wdata_i (stat_wdata),
    .re_i    (stat_re),
    .raddr_i (set_c),
    .rdata_o (stat_rdata)
  );

  // tags, one entry per line
  salc_ram #(
    .WIDTH (ADDRESS_WIDTH),
    .DEPTH (2 ** TAG_AW)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .waddr_i (tag_waddr),
    .wdata_i (tag_q),
    .re_i    (tag_re),
    .raddr_i (tag_raddr),
    .rdata_o (tag_rdata)
  );

  assign {rd_valid, rd_age} = stat_rdata;

  // shared tag comparator, one way per cycle
  assign cur_valid = rd_valid[cur_q];
  assign cur_age   = rd_age[cur_q];
  assign tag_hit   = cur_valid && (tag_rdata == tag_q);
  assign last_way  = (N_W'(cur_q) + N_W'(1)) == n_q;

  // way touched by this access
  always_comb begin
    if (found_q) begin
      upd_way     = hit_way_q;
      upd_outcome = OUT_HIT;
    end else if (vac_q) begin
      upd_way     = vac_way_q;
      upd_outcome = OUT_MISS;
    end else begin
      upd_way     = vic_way_q;
      upd_outcome = OUT_EVICT;
    end
  end

  salc_lru_update #(
    .MAX_WAYS (MAX_WAYS)
  ) u_lru (
    .valid_i  (rd_valid),
    .age_i    (rd_age),
    .n_ways_i (n_q),
    .way_i    (upd_way),
    .fill_i   (!found_q),
    .valid_o  (new_valid),
    .age_o    (new_age)
  );

  assign first_of_two = (cmd_q == CMD_MODIFY) && !pass_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_d = ST_INDEX;
        end
      end
      ST_INDEX: state_d = ST_SCAN;
      ST_SCAN: begin
        if (tag_hit || last_way) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: state_d = first_of_two ? ST_INDEX : ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // outputs and ram controls
  always_comb begin
    busy       = (state_q != ST_IDLE);
    stat_we    = 1'b0;
    stat_waddr = set_q;
    stat_wdata = {new_valid, new_age};
    stat_re    = 1'b0;
    tag_we     = 1'b0;
    tag_waddr  = {set_q, upd_way};
    tag_re     = 1'b0;
    tag_raddr  = {set_c, WAY_W'(0)};
    case (state_q)
      ST_CLEAR: begin
        stat_we    = 1'b1;
        stat_waddr = clr_q;
        stat_wdata = '0;
      end
      ST_INDEX: begin
        stat_re = 1'b1;
        tag_re  = 1'b1;
      end
      ST_SCAN: begin
        tag_re    = 1'b1;
        tag_raddr = {set_q, cur_q + WAY_W'(1)};
      end
      ST_UPDATE: begin
        stat_we = 1'b1;
        tag_we  = !found_q;
      end
      default: ;
    endcase
  end

  // datapath next values
  always_comb begin
    pass_d      = pass_q;
    clr_d       = clr_q;
    cmd_d       = cmd_q;
    addr_d      = addr_q;
    set_d       = set_q;
    tag_d       = tag_q;
    n_d         = n_q;
    cur_d       = cur_q;
    found_d     = found_q;
    hit_way_d   = hit_way_q;
    vac_d       = vac_q;
    vac_way_d   = vac_way_q;
    vic_way_d   = vic_way_q;
    vic_age_d   = vic_age_q;
    hits_d      = hits_q;
    misses_d    = misses_q;
    evicts_d    = evicts_q;
    rsp_d       = rsp_q;
    rsp_valid_d = 1'b0;
    case (state_q)
      ST_CLEAR: clr_d = clr_q + SET_W'(1);
      ST_IDLE: begin
        if (start) begin
          cmd_d  = req_i.command;
          addr_d = req_i.address;
          pass_d = 1'b0;
        end
      end
      ST_INDEX: begin
        set_d   = set_c;
        tag_d   = tag_c;
        n_d     = n_c;
        cur_d   = '0;
        found_d = 1'b0;
        vac_d   = 1'b0;
      end
      ST_SCAN: begin
        if (!cur_valid && !vac_q) begin
          vac_d     = 1'b1;
          vac_way_d = cur_q;
        end
        if ((cur_q == '0) || (cur_age > vic_age_q)) begin
          vic_way_d = cur_q;
          vic_age_d = cur_age;
        end
        if (tag_hit) begin
          found_d   = 1'b1;
          hit_way_d = cur_q;
        end
        cur_d = cur_q + WAY_W'(1);
      end
      ST_UPDATE: begin
        // saturating counts
        if (found_q) begin
          hits_d = (hits_q == '1) ? hits_q : hits_q + CNT_W'(1);
        end else begin
          misses_d = (misses_q == '1) ? misses_q : misses_q + CNT_W'(1);
          if (!vac_q) begin
            evicts_d = (evicts_q == '1) ? evicts_q : evicts_q + CNT_W'(1);
          end
        end
        rsp_d.outcome        = upd_outcome;
        rsp_d.last           = !first_of_two;
        rsp_d.hit_count      = hits_d;
        rsp_d.miss_count     = misses_d;
        rsp_d.eviction_count = evicts_d;
        rsp_valid_d          = 1'b1;
        if (first_of_two) begin
          pass_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      pass_q      <= 1'b0;
      clr_q       <= '0;
      found_q     <= 1'b0;
      vac_q       <= 1'b0;
      hits_q      <= '0;
      misses_q    <= '0;
      evicts_q    <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pass_q      <= pass_d;
      clr_q       <= clr_d;
      found_q     <= found_d;
      vac_q       <= vac_d;
      hits_q      <= hits_d;
      misses_q    <= misses_d;
      evicts_q    <= evicts_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    addr_q    <= addr_d;
    set_q     <= set_d;
    tag_q     <= tag_d;
    n_q       <= n_d;
    cur_q     <= cur_d;
    hit_way_q <= hit_way_d;
    vac_way_q <= vac_way_d;
    vic_way_q <= vic_way_d;
    vic_age_q <= vic_age_d;
    rsp_q     <= rsp_d;
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // checks on the sequencer
  `SALC_ASSERT_NEXT(a_update_gives_rsp, state_q == ST_UPDATE, rsp_valid_o, "update without result")
  `SALC_ASSERT(a_rsp_from_update, rsp_valid_o |-> $past(state_q == ST_UPDATE), "stray result strobe")
  `SALC_ASSERT(a_first_then_index, (rsp_valid_o && !rsp_o.last) |-> (state_q == ST_INDEX), "modify did not repeat")
  `SALC_ASSERT(a_second_is_hit, (rsp_valid_o && rsp_o.last && $past(pass_q)) |-> (rsp_o.outcome == OUT_HIT), "second access of modify missed")

endmodule

[hw/rtl/salc_ram.sv]
// ----------------------------------------------------------------------------
// salc_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/salc_addr_split.sv]
// ----------------------------------------------------------------------------
// salc_addr_split
// splits an address into set index and tag, and clamps the way count
// ----------------------------------------------------------------------------
module salc_addr_split import salc_pkg::*; #(
  parameter int MAX_SET_BITS  = 8,
  parameter int MAX_WAYS      = 8,
  parameter int ADDRESS_WIDTH = 64
) (
  input  logic [ADDR_W-1:0]                  address_i,
  input  logic [SET_BITS_W-1:0]              set_bits_i,
  input  logic [BLOCK_BITS_W-1:0]            block_bits_i,
  input  logic [WAYS_W-1:0]                  ways_i,
  output logic [((MAX_SET_BITS > 0) ? MAX_SET_BITS : 1)-1:0] set_o,
  output logic [ADDRESS_WIDTH-1:0]           tag_o,
  output logic [$clog2(MAX_WAYS+1)-1:0]      n_ways_o
);

  localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int N_W   = $clog2(MAX_WAYS + 1);
  localparam int SB_W  = SET_BITS_W + 1;
  localparam int SH_W  = BLOCK_BITS_W + 1;

  logic [ADDRESS_WIDTH-1:0] addr_cut;
  logic [SB_W-1:0]          sb;
  logic [SET_W-1:0]         idx_mask;
  logic [ADDRESS_WIDTH-1:0] set_full;
  logic [SH_W-1:0]          tag_shamt;

  // address cut to the modelled width
  assign addr_cut = address_i[ADDRESS_WIDTH-1:0];

  // set bits clamped to the largest supported index
  assign sb = (SB_W'(set_bits_i) > SB_W'(MAX_SET_BITS)) ? SB_W'(MAX_SET_BITS)
                                                       : SB_W'(set_bits_i);

  // set index: bits just above the block offset, shifts past the top give zero
  assign set_full = addr_cut >> block_bits_i;
  assign idx_mask = (SET_W'(1) << sb) - SET_W'(1);
  assign set_o    = SET_W'(set_full) & idx_mask;

  // tag: everything above the set index
  assign tag_shamt = SH_W'(block_bits_i) + SH_W'(sb);
  assign tag_o     = addr_cut >> tag_shamt;

  // ways in use, zero counts as one
  always_comb begin
    if (ways_i == '0) begin
      n_ways_o = N_W'(1);
    end else if (32'(ways_i) > MAX_WAYS) begin
      n_ways_o = N_W'(MAX_WAYS);
    end else begin
      n_ways_o = N_W'(ways_i);
    end
  end

endmodule

[hw/rtl/salc_lru_update.sv]
// ----------------------------------------------------------------------------
// salc_lru_update
// new valid and age row of a set after an access to one way
// ----------------------------------------------------------------------------
module salc_lru_update import salc_pkg::*; #(
  parameter int MAX_WAYS = 8
) (
  input  logic [MAX_WAYS-1:0]                         valid_i,
  input  logic [MAX_WAYS-1:0][AGE_W-1:0]              age_i,
  input  logic [$clog2(MAX_WAYS+1)-1:0]               n_ways_i,
  input  logic [((MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1)-1:0] way_i,
  input  logic                                        fill_i,
  output logic [MAX_WAYS-1:0]                         valid_o,
  output logic [MAX_WAYS-1:0][AGE_W-1:0]              age_o
);

  localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int N_W   = $clog2(MAX_WAYS + 1);

  logic [AGE_W:0] old_age;

  // an invalid way counts as older than every valid one
  assign old_age = valid_i[way_i] ? {1'b0, age_i[way_i]} : (AGE_W + 1)'(MAX_WAYS'(0) + 8);

  // age younger valid ways, accessed way becomes most recent
  always_comb begin
    valid_o = valid_i;
    age_o   = age_i;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (WAY_W'(i) == way_i) begin
        age_o[i] = '0;
      end else if ((N_W'(i) < n_ways_i) && valid_i[i] && ({1'b0, age_i[i]} < old_age)
                   && (age_i[i] != AGE_MAX)) begin
        age_o[i] = age_i[i] + AGE_W'(1);
      end
    end
    if (fill_i) begin
      valid_o[way_i] = 1'b1;
    end
  end

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench for set_assoc_lru_cache_model_top
// drives loads, stores and modifies through the start/busy port and checks
// every result strobe against a tag-level lru cache predictor kept in the
// bench; a directed table comes first, then random traffic under a series of
// cache geometries written between phases
// ----------------------------------------------------------------------------
module testbench;
  import salc_pkg::*;

  localparam int SET_LIMIT  = 8;
  localparam int WAY_LIMIT  = 8;
  localparam int LINE_TOTAL = (1 << SET_LIMIT) * WAY_LIMIT;
  localparam int POOL_MAX   = 32;
  localparam int SUB_ITEMS  = 146;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  req_t                  req_i;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  rsp_valid_o;
  rsp_t                  rsp_o;

  // one row of the directed table: a register write or a request
  typedef struct {
    bit               is_cfg;
    cfg_idx_e         idx;
    logic [5:0]       data;
    logic [1:0]       cmd;
    logic [63:0]      addr;
    bit               fixed;
    outcome_e         want;
  } row_t;

  // predicted cache contents and geometry
  logic [63:0]    tag_mem   [LINE_TOTAL];
  bit             valid_mem [LINE_TOTAL];
  logic [2:0]     age_mem   [LINE_TOTAL];
  logic [31:0]    hit_cnt, miss_cnt, evict_cnt;
  logic [3:0]     set_bits_r;
  logic [5:0]     block_bits_r;
  logic [3:0]     ways_r;

  rsp_t           pending_rsp_q [$];
  row_t           directed_rows [$];
  logic [63:0]    hot_pool [POOL_MAX];
  int             pool_len;
  int             gap_pct;
  int             fail_cnt;
  int             gap_plan [3] = '{26, 48, 0};

  set_assoc_lru_cache_model_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  // one access to the predicted cache; returns its outcome
  function automatic outcome_e cache_access(logic [63:0] addr);
    int sb, nw, set_idx, base, w, old;
    logic [63:0] tag;
    bit found, vacant;
    sb = (set_bits_r > 4'd8) ? SET_LIMIT : int'(set_bits_r);
    nw = (ways_r == 4'd0) ? 1 : ((ways_r > 4'd8) ? WAY_LIMIT : int'(ways_r));
    set_idx = int'((addr >> block_bits_r) & ((64'd1 << sb) - 64'd1));
    tag = addr >> (int'(block_bits_r) + sb);
    base = set_idx * WAY_LIMIT;
    found = 1'b0;
    vacant = 1'b0;
    w = 0;
    // tag match among valid ways
    for (int i = 0; i < nw; i++) begin
      if (!found && valid_mem[base + i] && tag_mem[base + i] == tag) begin
        w = i;
        found = 1'b1;
      end
    end
    // first empty way, else oldest valid way
    if (!found) begin
      for (int i = 0; i < nw; i++) begin
        if (!vacant && !valid_mem[base + i]) begin
          w = i;
          vacant = 1'b1;
        end
      end
      if (!vacant) begin
        w = 0;
        for (int i = 1; i < nw; i++) begin
          if (age_mem[base + i] > age_mem[base + w]) w = i;
        end
      end
    end
    // age the younger ways, touched way becomes newest
    old = valid_mem[base + w] ? int'(age_mem[base + w]) : 8;
    for (int i = 0; i < nw; i++) begin
      if (i != w && valid_mem[base + i] && int'(age_mem[base + i]) < old &&
          age_mem[base + i] < AGE_MAX)
        age_mem[base + i] = age_mem[base + i] + 3'd1;
    end
    age_mem[base + w] = '0;
    if (found) begin
      if (hit_cnt != '1) hit_cnt++;
      return OUT_HIT;
    end
    tag_mem[base + w] = tag;
    valid_mem[base + w] = 1'b1;
    if (miss_cnt != '1) miss_cnt++;
    if (vacant) return OUT_MISS;
    if (evict_cnt != '1) evict_cnt++;
    return OUT_EVICT;
  endfunction

  // expected results of one accepted request
  function automatic void predict_request(req_t r, bit fixed, outcome_e want);
    rsp_t e;
    int n;
    n = (r.command == CMD_MODIFY) ? 2 : 1;
    for (int k = 0; k < n; k++) begin
      e.outcome = cache_access(r.address);
      if (fixed && k == 0) e.outcome = want;
      e.last = (k == n - 1);
      e.hit_count = hit_cnt;
      e.miss_count = miss_cnt;
      e.eviction_count = evict_cnt;
      pending_rsp_q.push_back(e);
    end
  endfunction

  function automatic void check_field(string fname, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, fname, want, got);
      fail_cnt++;
    end
  endfunction

  // result checker
  always @(posedge clk_i) begin : rsp_check
    rsp_t e;
    if (rst_ni && rsp_valid_o === 1'b1) begin
      if (pending_rsp_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %0h", $time, rsp_o);
        fail_cnt++;
      end else begin
        e = pending_rsp_q.pop_front();
        check_field("outcome", 64'(e.outcome), 64'(rsp_o.outcome));
        check_field("last", 64'(e.last), 64'(rsp_o.last));
        check_field("hit_count", 64'(e.hit_count), 64'(rsp_o.hit_count));
        check_field("miss_count", 64'(e.miss_count), 64'(rsp_o.miss_count));
        check_field("eviction_count", 64'(e.eviction_count), 64'(rsp_o.eviction_count));
      end
    end
  end

  // present one request, with random gaps ahead of it; leaves start high
  task automatic issue(logic [1:0] cmd, logic [63:0] addr, bit fixed, outcome_e want);
    req_t r;
    r.command = cmd;
    r.address = addr;
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    predict_request(r, fixed, want);
    @(negedge clk_i);
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain();
    start <= 1'b0;
    do @(negedge clk_i); while (pending_rsp_q.size() != 0 || busy !== 1'b0);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [5:0] val);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_SET_BITS:   set_bits_r = val[3:0];
      CFG_BLOCK_BITS: block_bits_r = val;
      CFG_WAYS:       ways_r = val[3:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic void add_req(logic [1:0] cmd, logic [63:0] addr, bit fixed,
                                  outcome_e want);
    row_t r;
    r = '{is_cfg: 1'b0, idx: CFG_SET_BITS, data: '0, cmd: cmd, addr: addr,
          fixed: fixed, want: want};
    directed_rows.push_back(r);
  endfunction

  function automatic void add_cfg(cfg_idx_e idx, logic [5:0] data);
    row_t r;
    r = '{is_cfg: 1'b1, idx: idx, data: data, cmd: '0, addr: '0,
          fixed: 1'b0, want: OUT_HIT};
    directed_rows.push_back(r);
  endfunction

  // working set of addresses, each after the first forced into its set at even odds
  function automatic void refill_pool();
    logic [63:0] idx_mask;
    int sb;
    sb = (set_bits_r > 4'd8) ? SET_LIMIT : int'(set_bits_r);
    idx_mask = ((64'd1 << sb) - 64'd1) << block_bits_r;
    pool_len = $urandom_range(4, POOL_MAX);
    for (int k = 0; k < pool_len; k++) begin
      if ($urandom_range(1)) hot_pool[k] = {$urandom, $urandom};
      if (k > 0 && $urandom_range(1))
        hot_pool[k] = (hot_pool[k] & ~idx_mask) | (hot_pool[0] & idx_mask);
    end
  endfunction

  function automatic logic [63:0] pick_address();
    logic [63:0] off_mask;
    off_mask = (64'd1 << block_bits_r) - 64'd1;
    if ($urandom_range(99) < 10) return {$urandom, $urandom};
    return hot_pool[$urandom_range(pool_len - 1)] ^ ({$urandom, $urandom} & off_mask);
  endfunction

  // new random geometry, extremes included now and then
  task automatic shuffle_config();
    logic [5:0] sv, bv, wv;
    int r;
    r = $urandom_range(9);
    sv = (r < 6) ? 6'($urandom_range(4)) :
         (r < 8) ? 6'($urandom_range(5, 8)) : 6'($urandom_range(63));
    r = $urandom_range(9);
    bv = (r < 7) ? 6'($urandom_range(1, 8)) :
         (r < 9) ? 6'($urandom_range(9, 63)) : 6'd0;
    wv = 6'($urandom_range(15));
    write_reg(CFG_SET_BITS, sv);
    write_reg(CFG_BLOCK_BITS, bv);
    write_reg(CFG_WAYS, wv);
    refill_pool();
  endtask

  // stimulus
  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    req_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    fail_cnt = 0;
    gap_pct = 0;
    hit_cnt = '0;
    miss_cnt = '0;
    evict_cnt = '0;
    set_bits_r = 4'd0;
    block_bits_r = 6'd1;
    ways_r = 4'd1;
    for (int k = 0; k < LINE_TOTAL; k++) begin
      tag_mem[k] = '0;
      valid_mem[k] = 1'b0;
      age_mem[k] = '0;
    end
    for (int k = 0; k < POOL_MAX; k++) hot_pool[k] = {$urandom, $urandom};
    pool_len = POOL_MAX;

    // reset geometry: one set, one way, two-byte blocks
    add_req(CMD_LOAD, 64'h0, 1'b1, OUT_MISS);
    add_req(CMD_LOAD, 64'h1, 1'b1, OUT_HIT);
    add_req(CMD_STORE, 64'h2, 1'b1, OUT_EVICT);
    add_req(CMD_MODIFY, '1, 1'b1, OUT_EVICT);
    add_req(2'd3, 64'h0, 1'b1, OUT_EVICT);
    // four sets of four ways, fill one set past capacity for lru victims
    add_cfg(CFG_SET_BITS, 6'd2);
    add_cfg(CFG_BLOCK_BITS, 6'd4);
    add_cfg(CFG_WAYS, 6'd4);
    add_req(CMD_LOAD, 64'h000, 1'b0, OUT_HIT);
    add_req(CMD_STORE, 64'h040, 1'b0, OUT_HIT);
    add_req(CMD_LOAD, 64'h080, 1'b0, OUT_HIT);
    add_req(CMD_STORE, 64'h0C0, 1'b0, OUT_HIT);
    add_req(CMD_LOAD, 64'h00F, 1'b0, OUT_HIT);
    add_req(CMD_MODIFY, 64'h100, 1'b0, OUT_HIT);
    add_req(CMD_LOAD, 64'h040, 1'b0, OUT_HIT);
    // set bits beyond the limit, widest offset, zero ways
    add_cfg(CFG_SET_BITS, 6'd15);
    add_cfg(CFG_BLOCK_BITS, 6'd63);
    add_cfg(CFG_WAYS, 6'd0);
    add_req(CMD_LOAD, '1, 1'b0, OUT_HIT);
    add_req(CMD_MODIFY, 64'h0, 1'b0, OUT_HIT);
    // most sets, way count beyond the limit
    add_cfg(CFG_SET_BITS, 6'd8);
    add_cfg(CFG_BLOCK_BITS, 6'd32);
    add_cfg(CFG_WAYS, 6'd15);
    add_req(CMD_MODIFY, 64'hFFFF_FFFF_0000_0000, 1'b0, OUT_HIT);
    add_req(CMD_LOAD, 64'h8000_0000_0000_0000, 1'b0, OUT_HIT);
    add_req(CMD_STORE, 64'h0000_00FF_8000_0001, 1'b0, OUT_HIT);
    // no offset at all, full eight ways
    add_cfg(CFG_BLOCK_BITS, 6'd0);
    add_cfg(CFG_WAYS, 6'd8);
    add_req(CMD_LOAD, 64'h0000_0000_0000_0001, 1'b0, OUT_HIT);
    add_req(CMD_MODIFY, 64'h0000_0000_0000_0101, 1'b0, OUT_HIT);

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg)
        write_reg(directed_rows[i].idx, directed_rows[i].data);
      else
        issue(directed_rows[i].cmd, directed_rows[i].addr, directed_rows[i].fixed,
              directed_rows[i].want);
    end

    // random traffic, three phases of request gaps, four geometries each
    for (int p = 0; p < 3; p++) begin
      gap_pct = gap_plan[p];
      for (int s = 0; s < 4; s++) begin
        shuffle_config();
        for (int i = 0; i < SUB_ITEMS; i++) begin
          if ($urandom_range(99) == 0) drain();
          issue(2'($urandom_range(3)), pick_address(), 1'b0, OUT_HIT);
        end
      end
    end

    drain();
    repeat (30) @(negedge clk_i);
    if (fail_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
